/* hw/rtl/mrff_pkg.sv */
// Shared constants, types and the CRC byte step for the mesh relay frame filter.
package mrff_pkg;

  localparam int HISTORY_DEPTH = 32;
  localparam int BODY_BYTES    = 100;
  localparam int ID_AREA       = 9;
  localparam int FROM_AREA     = 16;
  localparam int TAG_BYTES     = 8;
  localparam int MSG_BYTES     = ID_AREA + FROM_AREA + BODY_BYTES;
  localparam int FRAME_BYTES   = MSG_BYTES + 2;
  localparam int HIST_AW       = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_TOP  = 16'h8000;

  typedef enum logic [1:0] {
    V_FORWARD = 2'd0,
    V_LENGTH  = 2'd1,
    V_CRC     = 2'd2,
    V_DUP     = 2'd3
  } verdict_e;

  typedef struct packed {
    logic [15:0] crc;
    logic [63:0] tag;
    logic [7:0]  count;
    logic [15:0] trailer;
  } frame_sum_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* hw/rtl/mrff_in_if.sv */
// Byte request channel into the frame filter.
interface mrff_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;

  modport source (output valid, output frame_byte, output frame_end, input ready);
  modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

/* hw/rtl/mrff_out_if.sv */
// Verdict request channel out of the frame filter.
interface mrff_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  verdict;
  logic [15:0] computed_check;
  logic [63:0] message_tag;
  logic [7:0]  byte_count;

  modport source (output valid, output verdict, output computed_check,
                  output message_tag, output byte_count, input ready);
  modport sink   (input valid, input verdict, input computed_check,
                  input message_tag, input byte_count, output ready);
endinterface

/* hw/rtl/mrff_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module mrff_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/mrff_front.sv */
// Front end: takes frame bytes, runs the CRC, captures id and trailer, counts length.
module mrff_front import mrff_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  mrff_in_if.sink    in_ch,
  input  logic       q_full_i,
  output logic       q_push_o,
  output frame_sum_t q_data_o
);

  logic [15:0] crc_q, crc_d;
  logic [7:0]  pos_q, count;
  logic [63:0] tag_q, tag_d;
  logic        nul_q, nul_d;
  logic [15:0] trl_q, trl_d;
  logic        accept;

  assign in_ch.ready = !q_full_i;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    crc_d = crc_q;
    tag_d = tag_q;
    nul_d = nul_q;
    trl_d = trl_q;
    if (pos_q < 8'(MSG_BYTES)) begin
      crc_d = crc_byte(crc_q, in_ch.frame_byte);
    end
    if (pos_q < 8'(TAG_BYTES)) begin
      if (nul_q || in_ch.frame_byte == 8'h00) begin
        nul_d = 1'b1;
      end else begin
        tag_d[{pos_q[2:0], 3'b000} +: 8] = in_ch.frame_byte;
      end
    end
    if (pos_q == 8'(MSG_BYTES)) begin
      trl_d[7:0] = in_ch.frame_byte;
    end else if (pos_q == 8'(MSG_BYTES + 1)) begin
      trl_d[15:8] = in_ch.frame_byte;
    end
    count = (pos_q != 8'hFF) ? pos_q + 8'd1 : 8'hFF;
  end

  assign q_push_o         = accept && in_ch.frame_end;
  assign q_data_o.crc     = crc_d;
  assign q_data_o.tag     = tag_d;
  assign q_data_o.count   = count;
  assign q_data_o.trailer = trl_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CRC_INIT;
      pos_q <= '0;
      tag_q <= '0;
      nul_q <= 1'b0;
      trl_q <= '0;
    end else if (accept) begin
      if (in_ch.frame_end) begin
        // restart the per-frame state
        crc_q <= CRC_INIT;
        pos_q <= '0;
        tag_q <= '0;
        nul_q <= 1'b0;
        trl_q <= '0;
      end else begin
        crc_q <= crc_d;
        pos_q <= count;
        tag_q <= tag_d;
        nul_q <= nul_d;
        trl_q <= trl_d;
      end
    end
  end

endmodule

/* hw/rtl/mrff_fifo.sv */
// Short queue of frame summaries between the front and back ends.
module mrff_fifo import mrff_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  frame_sum_t push_data_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       valid_o,
  output frame_sum_t pop_data_o
);

  frame_sum_t          ent_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]     cnt_q;
  logic                do_push, do_pop;

  assign full_o     = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = ent_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/mrff_back.sv */
// Back end: length and CRC checks, history scan, history update and result register.
module mrff_back import mrff_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  frame_sum_t q_data_i,
  output logic       q_pop_o,
  mrff_out_if.source out_ch
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  state_e             state_q, state_d;
  frame_sum_t         cur_q, cur_d;
  verdict_e           verd_q, verd_d;
  logic [HIST_AW-1:0] idx_q, idx_d;
  logic [HIST_AW-1:0] cmp_idx_q, cmp_idx_d;
  logic               cmp_vld_q, cmp_vld_d;
  logic               dup_q, dup_d;
  logic [HIST_AW-1:0] wslot_q, wslot_d;
  logic               hist_vld_q [HISTORY_DEPTH];
  logic               ram_we, ram_re;
  logic [63:0]        ram_rdata, entry;
  logic               hit;

  logic        out_valid_q, out_valid_d;
  logic [1:0]  out_verd_q;
  logic [15:0] out_crc_q;
  logic [63:0] out_tag_q;
  logic [7:0]  out_cnt_q;
  logic        out_free, out_load;

  mrff_ram #(
    .WIDTH (64),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wslot_q),
    .wdata_i (cur_q.tag),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  // never-written entries read as zero
  assign entry    = hist_vld_q[cmp_idx_q] ? ram_rdata : 64'h0;
  assign hit      = cmp_vld_q && (entry == cur_q.tag);
  assign out_free = !out_valid_q || out_ch.ready;

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    verd_d      = verd_q;
    idx_d       = idx_q;
    cmp_idx_d   = idx_q;
    cmp_vld_d   = 1'b0;
    dup_d       = dup_q | hit;
    wslot_d     = wslot_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    q_pop_o     = 1'b0;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && !out_ch.ready;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cur_d   = q_data_i;
          dup_d   = 1'b0;
          idx_d   = '0;
          if (q_data_i.count != 8'(FRAME_BYTES)) begin
            verd_d  = V_LENGTH;
            state_d = ST_EMIT;
          end else if (q_data_i.trailer != q_data_i.crc) begin
            verd_d  = V_CRC;
            state_d = ST_EMIT;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        ram_re    = 1'b1;
        cmp_vld_d = 1'b1;
        if (idx_q == HIST_AW'(HISTORY_DEPTH - 1)) begin
          state_d = ST_DRAIN;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        verd_d  = dup_d ? V_DUP : V_FORWARD;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          if (verd_q == V_FORWARD) begin
            ram_we  = 1'b1;
            wslot_d = (wslot_q == HIST_AW'(HISTORY_DEPTH - 1)) ? '0 : wslot_q + 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      verd_q      <= V_FORWARD;
      idx_q       <= '0;
      cmp_idx_q   <= '0;
      cmp_vld_q   <= 1'b0;
      dup_q       <= 1'b0;
      wslot_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_vld_q[i] <= 1'b0;
      end
    end else begin
      state_q     <= state_d;
      verd_q      <= verd_d;
      idx_q       <= idx_d;
      cmp_idx_q   <= cmp_idx_d;
      cmp_vld_q   <= cmp_vld_d;
      dup_q       <= dup_d;
      wslot_q     <= wslot_d;
      out_valid_q <= out_valid_d;
      if (ram_we) begin
        hist_vld_q[wslot_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (out_load) begin
      out_verd_q <= verd_q;
      out_crc_q  <= cur_q.crc;
      out_tag_q  <= cur_q.tag;
      out_cnt_q  <= cur_q.count;
    end
  end

  assign out_ch.valid          = out_valid_q;
  assign out_ch.verdict        = out_verd_q;
  assign out_ch.computed_check = out_crc_q;
  assign out_ch.message_tag    = out_tag_q;
  assign out_ch.byte_count     = out_cnt_q;

endmodule

/* hw/rtl/mesh_relay_frame_filter_unit.sv */
// Top level of the mesh relay frame filter: front end, summary queue, back end.
//
//   channel  | dir | payload                                             | per item
//   in_ch    | in  | frame_byte[7:0], frame_end                          | one frame byte
//   out_ch   | out | verdict[1:0], computed_check[15:0],                 | one verdict per
//            |     | message_tag[63:0], byte_count[7:0]                  | frame
//
// The front end takes one byte per cycle while the summary queue is not full; the CRC
// step runs in that same cycle. The back end sends a frame rejected for length or CRC
// straight to the result stage; others scan the history RAM, one entry a cycle.
// A queue of QUEUE_DEPTH frame summaries sits between them; in_ch.ready drops
// only while that queue is full, and the result register waits on out_ch.ready.
// Reset clears the history valid bits at once, so the history reads as all zeros.
module mesh_relay_frame_filter_unit import mrff_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  mrff_in_if.sink    in_ch,
  mrff_out_if.source out_ch
);

  logic       q_full, q_push, q_valid, q_pop;
  frame_sum_t q_wdata, q_rdata;

  mrff_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch    (in_ch),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_data_o (q_wdata)
  );

  mrff_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_rdata)
  );

  mrff_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (q_rdata),
    .q_pop_o   (q_pop),
    .out_ch    (out_ch)
  );

endmodule
